FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/tqm_pkg.sv
// ----------------------------------------------------------------------------
// tqm_pkg
// Widths, fixed-point formats and helper functions of the triangle metrics.
// ----------------------------------------------------------------------------
`default_nettype none

package tqm_pkg;

	// Formats
	localparam int COORD_WIDTH          = 16;
	localparam int LENGTH_FRACTION_BITS = 8;
	localparam int SHAPE_FRACTION_BITS  = 16;
	localparam int AREA_FRACTION_BITS   = 4;
	localparam int LEN_OUT_W            = 25;
	localparam int AREA_OUT_W           = 37;
	localparam int SHAPE_OUT_W          = SHAPE_FRACTION_BITS + 1;

	// Datapath widths
	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int EDGE_W  = 2 * DIFF_W;
	localparam int ESUM_W  = EDGE_W + 2;
	localparam int CS_W    = 4 * DIFF_W;

	// Square root argument widths (all even)
	localparam int LONG_ARG_W = EDGE_W + 2 * LENGTH_FRACTION_BITS;
	localparam int AREA_ARG_W = CS_W + 2 * (AREA_FRACTION_BITS - 1);
	localparam int EQ_SHIFT   = 2 + 4 * LENGTH_FRACTION_BITS;
	localparam int EQ1_ARG_W  = CS_W + EQ_SHIFT;
	localparam int EQ2_ARG_W  = EQ1_ARG_W / 2 + (EQ1_ARG_W / 2) % 2;
	localparam int SHAPE_ARG_W = CS_W + 4 + 2 * SHAPE_FRACTION_BITS;

	// Divide-by-three sweep
	localparam int DIV3_GROUP = 8;
	localparam int DIV3_STEPS = (CS_W + DIV3_GROUP - 1) / DIV3_GROUP;
	localparam int DIV3_W     = DIV3_STEPS * DIV3_GROUP;

	// Shape quotient
	localparam int SHQ_W = SHAPE_FRACTION_BITS + 1;
	localparam int DV_W  = (SHAPE_ARG_W / 2 > ESUM_W + SHQ_W) ?
		SHAPE_ARG_W / 2 : ESUM_W + SHQ_W;

	// Branch depths after the front stages
	localparam int FRONT_STAGES = 5;
	localparam int LAT_EQ    = DIV3_STEPS + EQ1_ARG_W / 2 + EQ2_ARG_W / 2;
	localparam int LAT_SHAPE = SHAPE_ARG_W / 2 + 1 + SHQ_W;
	localparam int LAT_A     = (LONG_ARG_W / 2 > AREA_ARG_W / 2) ?
		LONG_ARG_W / 2 : AREA_ARG_W / 2;
	localparam int LAT_B     = (LAT_EQ > LAT_SHAPE) ? LAT_EQ : LAT_SHAPE;
	localparam int LAT_TOTAL = (LAT_A > LAT_B) ? LAT_A : LAT_B;

	localparam int SAT_W = 64;

	// floor(2^EQ_SHIFT / 3); EQ_SHIFT is even so 2^EQ_SHIFT - 1 divides exactly
	localparam logic [EQ_SHIFT-1:0] EQ_ONES  = '1;
	localparam logic [EQ_SHIFT-1:0] EQ_THIRD = EQ_ONES / 3;

	// Low part of floor(rem * 2^EQ_SHIFT / 3) for a remainder of the divide by three
	function automatic logic [EQ_SHIFT-1:0] third_frac(input logic [1:0] r);
		logic [EQ_SHIFT-1:0] f;
		case (r)
			2'd1:    f = EQ_THIRD;
			2'd2:    f = EQ_THIRD << 1;
			default: f = '0;
		endcase
		return f;
	endfunction

	// Clamp to the all-ones value of a field of w bits
	function automatic logic [SAT_W-1:0] sat_to(input logic [SAT_W-1:0] v, input int w);
		logic [SAT_W-1:0] lim;
		lim = (SAT_W'(1) << w) - SAT_W'(1);
		return (v > lim) ? lim : v;
	endfunction

endpackage

`default_nettype wire

FILE: src/tqm_isqrt.sv
// ----------------------------------------------------------------------------
// tqm_isqrt
// Pipelined integer square root, one result bit per stage, padded to LAT.
// ----------------------------------------------------------------------------
`default_nettype none

module tqm_isqrt #(
	parameter int AW  = tqm_pkg::LONG_ARG_W,
	parameter int LAT = tqm_pkg::LAT_TOTAL
) (
	input  logic            clk,
	input  logic            en,
	input  logic [AW-1:0]   arg,
	output logic [AW/2-1:0] root
);

	localparam int N  = AW / 2;
	localparam int RW = N + 2;

	logic [RW-1:0] rem_s  [1:LAT];
	logic [N-1:0]  root_s [1:LAT];
	logic [AW-1:0] arg_s  [1:LAT];

	for (genvar k = 0; k < LAT; k++) begin : g_st
		logic [RW-1:0] rem_in;
		logic [N-1:0]  root_in;
		logic [AW-1:0] arg_in;

		// select stage input
		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign arg_in  = arg;
		end else begin : g_next
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
			assign arg_in  = arg_s[k];
		end

		if (k < N) begin : g_iter
			logic [RW-1:0] rem_sh;
			logic [RW-1:0] trial;
			logic          ge;

			// bring down two argument bits and try the next root bit
			always_comb begin
				rem_sh = {rem_in[RW-3:0], arg_in[AW-1 -: 2]};
				trial  = {root_in, 2'b01};
				ge     = (rem_sh >= trial);
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
					root_s[k+1] <= {root_in[N-2:0], ge};
					arg_s[k+1]  <= arg_in << 2;
				end
			end
		end else begin : g_pass
			// hold the finished root to line up with the other branches
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1]  <= rem_in;
					root_s[k+1] <= root_in;
					arg_s[k+1]  <= arg_in;
				end
			end
		end
	end

	assign root = root_s[LAT];

endmodule

`default_nettype wire

FILE: src/triangle_quality_metrics_top.sv
// ----------------------------------------------------------------------------
// triangle_quality_metrics_top
// Triangle edge, area, equivalent size and shape quality in fixed point.
// ----------------------------------------------------------------------------
// Fully pipelined: one triangle is accepted every clock while not stalled, and
// each result passes through 5 front stages for differences, products, cross
// product and squared edges, 86 stages for the deepest branch - the divide by
// three and the two chained one-bit-per-stage square roots of the equivalent
// size - and one output register. All branches are padded to that depth.
// Back-pressure stops the whole pipeline only when the last stage holds an
// item and the output register is still full; no reset-time clearing pass.
`default_nettype none

module triangle_quality_metrics_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [tqm_pkg::COORD_WIDTH-1:0] first_x,
	input  logic [tqm_pkg::COORD_WIDTH-1:0] first_y,
	input  logic [tqm_pkg::COORD_WIDTH-1:0] first_z,
	input  logic [tqm_pkg::COORD_WIDTH-1:0] second_x,
	input  logic [tqm_pkg::COORD_WIDTH-1:0] second_y,
	input  logic [tqm_pkg::COORD_WIDTH-1:0] second_z,
	input  logic [tqm_pkg::COORD_WIDTH-1:0] third_x,
	input  logic [tqm_pkg::COORD_WIDTH-1:0] third_y,
	input  logic [tqm_pkg::COORD_WIDTH-1:0] third_z,
	output logic out_valid,
	input  logic out_ready,
	output logic [tqm_pkg::LEN_OUT_W-1:0]   max_edge_len,
	output logic [tqm_pkg::AREA_OUT_W-1:0]  area_value,
	output logic [tqm_pkg::LEN_OUT_W-1:0]   equiv_edge,
	output logic [tqm_pkg::SHAPE_OUT_W-1:0] shape_quality,
	output logic                            is_degenerate
);

	localparam int CW   = tqm_pkg::COORD_WIDTH;
	localparam int DW   = tqm_pkg::DIFF_W;
	localparam int PW   = tqm_pkg::PROD_W;
	localparam int XW   = tqm_pkg::CROSS_W;
	localparam int EW   = tqm_pkg::EDGE_W;
	localparam int ESW  = tqm_pkg::ESUM_W;
	localparam int CSW  = tqm_pkg::CS_W;
	localparam int SF   = tqm_pkg::SHAPE_FRACTION_BITS;
	localparam int SQW  = tqm_pkg::SHQ_W;
	localparam int DVW  = tqm_pkg::DV_W;
	localparam int D3S  = tqm_pkg::DIV3_STEPS;
	localparam int D3W  = tqm_pkg::DIV3_W;
	localparam int D3G  = tqm_pkg::DIV3_GROUP;
	localparam int LT   = tqm_pkg::LAT_TOTAL;
	localparam int VD   = tqm_pkg::FRONT_STAGES + LT;
	localparam int SATW = tqm_pkg::SAT_W;

	localparam int LA_W  = tqm_pkg::LONG_ARG_W;
	localparam int AR_W  = tqm_pkg::AREA_ARG_W;
	localparam int E1_W  = tqm_pkg::EQ1_ARG_W;
	localparam int E2_W  = tqm_pkg::EQ2_ARG_W;
	localparam int SH_W  = tqm_pkg::SHAPE_ARG_W;
	localparam int E2LAT = LT - D3S - E1_W / 2;
	localparam int SHLAT = LT - 1 - SQW;

	localparam logic [SQW-1:0] SHAPE_ONE = SQW'(1) << SF;

	logic en;

	// ---------------- valid chain and stall ----------------
	logic vld_s [1:VD];
	logic out_valid_q;

	assign en       = !vld_s[VD] || !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= VD; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int i = 2; i <= VD; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// ---------------- stage 1: edge vectors ----------------
	logic signed [CW-1:0] pa [3];
	logic signed [CW-1:0] pb [3];
	logic signed [CW-1:0] pc [3];
	logic signed [DW-1:0] du_s1 [3];
	logic signed [DW-1:0] dv_s1 [3];
	logic signed [DW-1:0] dw_s1 [3];

	assign pa[0] = first_x;
	assign pa[1] = first_y;
	assign pa[2] = first_z;
	assign pb[0] = second_x;
	assign pb[1] = second_y;
	assign pb[2] = second_z;
	assign pc[0] = third_x;
	assign pc[1] = third_y;
	assign pc[2] = third_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				du_s1[i] <= DW'(pb[i]) - DW'(pa[i]);
				dv_s1[i] <= DW'(pc[i]) - DW'(pa[i]);
				dw_s1[i] <= DW'(pc[i]) - DW'(pb[i]);
			end
		end
	end

	// ---------------- stage 2: cross terms and squares ----------------
	logic signed [PW-1:0] xp_s2  [6];
	logic signed [PW-1:0] squ_s2 [3];
	logic signed [PW-1:0] sqv_s2 [3];
	logic signed [PW-1:0] sqw_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			xp_s2[0] <= PW'(du_s1[1]) * PW'(dv_s1[2]);
			xp_s2[1] <= PW'(du_s1[2]) * PW'(dv_s1[1]);
			xp_s2[2] <= PW'(du_s1[2]) * PW'(dv_s1[0]);
			xp_s2[3] <= PW'(du_s1[0]) * PW'(dv_s1[2]);
			xp_s2[4] <= PW'(du_s1[0]) * PW'(dv_s1[1]);
			xp_s2[5] <= PW'(du_s1[1]) * PW'(dv_s1[0]);
			for (int i = 0; i < 3; i++) begin
				squ_s2[i] <= PW'(du_s1[i]) * PW'(du_s1[i]);
				sqv_s2[i] <= PW'(dv_s1[i]) * PW'(dv_s1[i]);
				sqw_s2[i] <= PW'(dw_s1[i]) * PW'(dw_s1[i]);
			end
		end
	end

	// ---------------- stage 3: cross product, squared edges ----------------
	logic signed [XW-1:0] cr_s3 [3];
	logic [EW-1:0]        e_s3  [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) cr_s3[i] <= XW'(xp_s2[2*i]) - XW'(xp_s2[2*i+1]);
			e_s3[0] <= $unsigned(squ_s2[0]) + $unsigned(squ_s2[1]) + $unsigned(squ_s2[2]);
			e_s3[1] <= $unsigned(sqv_s2[0]) + $unsigned(sqv_s2[1]) + $unsigned(sqv_s2[2]);
			e_s3[2] <= $unsigned(sqw_s2[0]) + $unsigned(sqw_s2[1]) + $unsigned(sqw_s2[2]);
		end
	end

	// ---------------- stage 4: squared cross terms, max and sum ----------------
	logic signed [2*XW-1:0] cprod [3];
	logic [EW-1:0]          emax_c;
	logic [CSW-1:0]         csq_s4 [3];
	logic [EW-1:0]          emax_s4;
	logic [ESW-1:0]         esum_s4;

	for (genvar i = 0; i < 3; i++) begin : g_csq
		assign cprod[i] = cr_s3[i] * cr_s3[i];
	end

	always_comb begin
		emax_c = (e_s3[0] > e_s3[1]) ? e_s3[0] : e_s3[1];
		if (e_s3[2] > emax_c) emax_c = e_s3[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) csq_s4[i] <= cprod[i][CSW-1:0];
			emax_s4 <= emax_c;
			esum_s4 <= ESW'(e_s3[0]) + ESW'(e_s3[1]) + ESW'(e_s3[2]);
		end
	end

	// ---------------- stage 5: squared cross product length ----------------
	logic [CSW-1:0] cs_s5;
	logic [EW-1:0]  emax_s5;
	logic [ESW-1:0] esum_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s5   <= csq_s4[0] + csq_s4[1] + csq_s4[2];
			emax_s5 <= emax_s4;
			esum_s5 <= esum_s4;
		end
	end

	// ---------------- degenerate flag and sum delay lines ----------------
	logic           deg_s   [1:LT];
	logic [ESW-1:0] esdl_s  [1:SHLAT];

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s[1] <= (cs_s5 == '0);
			for (int i = 2; i <= LT; i++) deg_s[i] <= deg_s[i-1];
			esdl_s[1] <= esum_s5;
			for (int i = 2; i <= SHLAT; i++) esdl_s[i] <= esdl_s[i-1];
		end
	end

	// ---------------- longest edge and area roots ----------------
	logic [LA_W-1:0]   len_arg;
	logic [LA_W/2-1:0] len_root;
	logic [AR_W-1:0]   ar_arg;
	logic [AR_W/2-1:0] ar_root;

	assign len_arg = LA_W'(emax_s5) << (2 * tqm_pkg::LENGTH_FRACTION_BITS);
	assign ar_arg  = AR_W'(cs_s5) << (2 * (tqm_pkg::AREA_FRACTION_BITS - 1));

	tqm_isqrt #(.AW(LA_W), .LAT(LT)) u_len_sqrt (
		.clk  (clk),
		.en   (en),
		.arg  (len_arg),
		.root (len_root)
	);

	tqm_isqrt #(.AW(AR_W), .LAT(LT)) u_area_sqrt (
		.clk  (clk),
		.en   (en),
		.arg  (ar_arg),
		.root (ar_root)
	);

	// ---------------- equivalent size: divide by three, fourth root ----------------
	logic [D3W-1:0] d3_quo_s [1:D3S];
	logic [1:0]     d3_rem_s [1:D3S];

	for (genvar k = 0; k < D3S; k++) begin : g_d3
		logic [D3W-1:0] qin;
		logic [D3W-1:0] qout;
		logic [1:0]     rin;
		logic [1:0]     rout;

		if (k == 0) begin : g_first
			assign qin = D3W'(cs_s5);
			assign rin = '0;
		end else begin : g_next
			assign qin = d3_quo_s[k];
			assign rin = d3_rem_s[k];
		end

		// long division by three over one group of bits, quotient replaces dividend
		always_comb begin
			logic [2:0] acc;
			qout = qin;
			rout = rin;
			for (int b = 0; b < D3G; b++) begin
				acc = {rout, qin[D3W-1-D3G*k-b]};
				if (acc >= 3'd3) begin
					rout = 2'(acc - 3'd3);
					qout[D3W-1-D3G*k-b] = 1'b1;
				end else begin
					rout = acc[1:0];
					qout[D3W-1-D3G*k-b] = 1'b0;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d3_quo_s[k+1] <= qout;
				d3_rem_s[k+1] <= rout;
			end
		end
	end

	logic [E1_W-1:0]   eq1_arg;
	logic [E1_W/2-1:0] eq1_root;
	logic [E2_W-1:0]   eq2_arg;
	logic [E2_W/2-1:0] eq2_root;

	assign eq1_arg = {d3_quo_s[D3S][CSW-1:0], tqm_pkg::third_frac(d3_rem_s[D3S])};
	assign eq2_arg = E2_W'(eq1_root);

	tqm_isqrt #(.AW(E1_W), .LAT(E1_W / 2)) u_eq1_sqrt (
		.clk  (clk),
		.en   (en),
		.arg  (eq1_arg),
		.root (eq1_root)
	);

	tqm_isqrt #(.AW(E2_W), .LAT(E2LAT)) u_eq2_sqrt (
		.clk  (clk),
		.en   (en),
		.arg  (eq2_arg),
		.root (eq2_root)
	);

	// ---------------- shape: root of 12 cs, then divide by edge sum ----------------
	logic [SH_W-1:0]   sh_arg;
	logic [SH_W/2-1:0] sh_root;

	assign sh_arg = (SH_W'(cs_s5) << (3 + 2 * SF)) + (SH_W'(cs_s5) << (2 + 2 * SF));

	tqm_isqrt #(.AW(SH_W), .LAT(SHLAT)) u_shape_sqrt (
		.clk  (clk),
		.en   (en),
		.arg  (sh_arg),
		.root (sh_root)
	);

	logic [DVW-1:0] dv_rem_s  [1:SQW+1];
	logic [SQW-1:0] dv_quo_s  [1:SQW+1];
	logic [ESW-1:0] dv_esum_s [1:SQW+1];
	logic           dv_big_s  [1:SQW+1];

	// flag quotients that cannot fit and will clamp to one
	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[1]  <= DVW'(sh_root);
			dv_quo_s[1]  <= '0;
			dv_esum_s[1] <= esdl_s[SHLAT];
			dv_big_s[1]  <= DVW'(sh_root) >= (DVW'(esdl_s[SHLAT]) << SQW);
		end
	end

	for (genvar m = 1; m <= SQW; m++) begin : g_div
		logic [DVW-1:0] dvs;
		logic           ge;

		// restoring step for quotient bit SQW - m
		always_comb begin
			dvs = DVW'(dv_esum_s[m]) << (SQW - m);
			ge  = (dv_rem_s[m] >= dvs);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[m+1]  <= ge ? (dv_rem_s[m] - dvs) : dv_rem_s[m];
				dv_quo_s[m+1]  <= {dv_quo_s[m][SQW-2:0], ge};
				dv_esum_s[m+1] <= dv_esum_s[m];
				dv_big_s[m+1]  <= dv_big_s[m];
			end
		end
	end

	// ---------------- output formatting ----------------
	logic [SATW-1:0] len_sat;
	logic [SATW-1:0] ar_sat;
	logic [SATW-1:0] eq_sat;
	logic [SQW-1:0]  shape_c;
	logic            deg_c;

	assign deg_c   = deg_s[LT];
	assign len_sat = tqm_pkg::sat_to(SATW'(len_root), tqm_pkg::LEN_OUT_W);
	assign ar_sat  = tqm_pkg::sat_to(SATW'(ar_root), tqm_pkg::AREA_OUT_W);
	assign eq_sat  = tqm_pkg::sat_to(SATW'(eq2_root), tqm_pkg::LEN_OUT_W);

	always_comb begin
		if (deg_c) begin
			shape_c = '0;
		end else if (dv_big_s[SQW+1] || (dv_quo_s[SQW+1] > SHAPE_ONE)) begin
			shape_c = SHAPE_ONE;
		end else begin
			shape_c = dv_quo_s[SQW+1];
		end
	end

	// ---------------- output register ----------------
	logic [tqm_pkg::LEN_OUT_W-1:0]   longest_q;
	logic [tqm_pkg::AREA_OUT_W-1:0]  area_q;
	logic [tqm_pkg::LEN_OUT_W-1:0]   equiv_q;
	logic [tqm_pkg::SHAPE_OUT_W-1:0] shape_q;
	logic                            degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (vld_s[VD] && en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s[VD] && en) begin
			longest_q <= tqm_pkg::LEN_OUT_W'(len_sat);
			area_q    <= deg_c ? '0 : tqm_pkg::AREA_OUT_W'(ar_sat);
			equiv_q   <= deg_c ? '0 : tqm_pkg::LEN_OUT_W'(eq_sat);
			shape_q   <= shape_c;
			degen_q   <= deg_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign max_edge_len  = longest_q;
	assign area_value    = area_q;
	assign equiv_edge    = equiv_q;
	assign shape_quality = shape_q;
	assign is_degenerate = degen_q;

endmodule

`default_nettype wire

FILE: src/tqm_checker.sv
// ----------------------------------------------------------------------------
// tqm_checker
// Port-level checks of the triangle metrics block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tqm_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [tqm_pkg::LEN_OUT_W-1:0]   max_edge_len,
	input logic [tqm_pkg::AREA_OUT_W-1:0]  area_value,
	input logic [tqm_pkg::LEN_OUT_W-1:0]   equiv_edge,
	input logic [tqm_pkg::SHAPE_OUT_W-1:0] shape_quality,
	input logic                            is_degenerate
);

	// a stalled result stays valid and its area, shape and longest edge hold
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(area_value) && $stable(shape_quality) && $stable(max_edge_len), "result changed while stalled")

	// degenerate triangles carry no area, size or shape
	`ASSERT_CLK(a_degen_zero, clk, arst_n, out_valid && is_degenerate |-> area_value == '0 && equiv_edge == '0 && shape_quality == '0, "degenerate result not zeroed")

	// a proper triangle has a nonzero area
	`ASSERT_CLK(a_area_live, clk, arst_n, out_valid && !is_degenerate |-> area_value != '0 && equiv_edge != '0, "area lost on a proper triangle")

	// shape never exceeds one
	`ASSERT_CLK(a_shape_max, clk, arst_n, out_valid |-> shape_quality <= (tqm_pkg::SHAPE_OUT_W'(1) << tqm_pkg::SHAPE_FRACTION_BITS), "shape above one")

	// no result right after reset
	`ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !out_valid, "result valid after reset")

endmodule

bind triangle_quality_metrics_top tqm_checker u_tqm_checker (.*);

`default_nettype wire
